// ===== rtl/core/rsht_pkg.sv =====
// ----------------------------------------------------------------------------
// rsht_pkg: shared types and constants of the subject handle table
// Table sizes, field widths, operation and status codes, cell chain types.
// ----------------------------------------------------------------------------
package rsht_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int HANDLE_BITS   = 16;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int TYPE_W   = 2;
    localparam int ID_W     = 16;
    localparam int HRAW_W   = 17;
    localparam int STATUS_W = 3;
    localparam int RH_W     = 16;
    localparam int USAGE_W  = 16;

    // compare key covers both the stored handle and a request handle
    localparam int KEY_W  = (HANDLE_BITS > RH_W) ? HANDLE_BITS : RH_W;
    localparam int LIVE_W = $clog2(TABLE_ENTRIES + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INTEGRITY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    // write-back actions broadcast to the cells
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_INC   = 2'd1;
    localparam logic [1:0] ACT_ALLOC = 2'd2;
    localparam logic [1:0] ACT_DEC   = 2'd3;

    localparam logic [USAGE_W-1:0] USAGE_MAX = {USAGE_W{1'b1}};

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic [TYPE_W-1:0]      subject_type;
        logic [ID_W-1:0]        subject_id;
        logic                   key_en;
        logic [KEY_W-1:0]       key;
        logic [1:0]             action;
        logic [HANDLE_BITS-1:0] new_handle;
    } rsht_cmd_t;

    // first-hit flags and data passed from cell to cell
    typedef struct packed {
        logic                   id_hit;
        logic [HANDLE_BITS-1:0] id_handle;
        logic [USAGE_W-1:0]     id_usage;
        logic                   hnd_hit;
        logic [TYPE_W-1:0]      h_type;
        logic [ID_W-1:0]        h_id;
        logic [HANDLE_BITS-1:0] h_handle;
        logic [USAGE_W-1:0]     h_usage;
        logic                   free_hit;
    } rsht_chain_t;

endpackage

// ===== rtl/core/rsht_if.sv =====
// ----------------------------------------------------------------------------
// rsht_req_if / rsht_rsp_if: request and response channels
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface rsht_req_if
    import rsht_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [TYPE_W-1:0]       subject_type;
    logic [ID_W-1:0]         subject_id;
    logic signed [HRAW_W-1:0] subject_handle;

    modport source (output valid, opcode, subject_type, subject_id, subject_handle,
                    input ready);
    modport sink   (input valid, opcode, subject_type, subject_id, subject_handle,
                    output ready);
endinterface

interface rsht_rsp_if
    import rsht_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [RH_W-1:0]     result_handle;
    logic [TYPE_W-1:0]   result_type;
    logic [ID_W-1:0]     result_id;
    logic [USAGE_W-1:0]  usage_count;

    modport source (output valid, status, result_handle, result_type, result_id,
                    usage_count, input ready);
    modport sink   (input valid, status, result_handle, result_type, result_id,
                    usage_count, output ready);
endinterface

// ===== rtl/core/rsht_cell.sv =====
// ----------------------------------------------------------------------------
// rsht_cell: one table entry
// Holds one subject, compares it against the broadcast command, forwards
// first-hit flags and data to its neighbor and applies the write-back.
// ----------------------------------------------------------------------------
module rsht_cell
    import rsht_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rsht_cmd_t   cmd,
    input  rsht_chain_t chain_in,
    output rsht_chain_t chain_out
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [TYPE_W-1:0]      type_reg;
    logic [TYPE_W-1:0]      type_next;
    logic [ID_W-1:0]        id_reg;
    logic [ID_W-1:0]        id_next;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [HANDLE_BITS-1:0] handle_next;
    logic [USAGE_W-1:0]     usage_reg;
    logic [USAGE_W-1:0]     usage_next;

    logic [KEY_W-1:0] handle_key;
    logic             id_match;
    logic             hnd_match;
    logic             first_id;
    logic             first_hnd;
    logic             first_free;

    // local compares
    assign handle_key = KEY_W'(handle_reg);
    assign id_match   = valid_reg && (type_reg == cmd.subject_type)
                        && (id_reg == cmd.subject_id);
    assign hnd_match  = valid_reg && cmd.key_en && (handle_key == cmd.key);
    assign first_id   = id_match && !chain_in.id_hit;
    assign first_hnd  = hnd_match && !chain_in.hnd_hit;
    assign first_free = !valid_reg && !chain_in.free_hit;

    // forward the first hits down the row
    always_comb
    begin
        chain_out = chain_in;
        if (first_id)
        begin
            chain_out.id_hit    = 1'b1;
            chain_out.id_handle = handle_reg;
            chain_out.id_usage  = usage_reg;
        end
        if (first_hnd)
        begin
            chain_out.hnd_hit  = 1'b1;
            chain_out.h_type   = type_reg;
            chain_out.h_id     = id_reg;
            chain_out.h_handle = handle_reg;
            chain_out.h_usage  = usage_reg;
        end
        if (first_free)
        begin
            chain_out.free_hit = 1'b1;
        end
    end

    // write-back
    always_comb
    begin
        valid_next  = valid_reg;
        type_next   = type_reg;
        id_next     = id_reg;
        handle_next = handle_reg;
        usage_next  = usage_reg;
        case (cmd.action)
            ACT_INC:
            begin
                if (first_id && (usage_reg != USAGE_MAX))
                begin
                    usage_next = usage_reg + USAGE_W'(1);
                end
            end
            ACT_ALLOC:
            begin
                if (first_free)
                begin
                    valid_next  = 1'b1;
                    type_next   = cmd.subject_type;
                    id_next     = cmd.subject_id;
                    handle_next = cmd.new_handle;
                    usage_next  = USAGE_W'(1);
                end
            end
            ACT_DEC:
            begin
                if (first_hnd && (usage_reg != '0))
                begin
                    usage_next = usage_reg - USAGE_W'(1);
                    if (usage_reg == USAGE_W'(1))
                    begin
                        valid_next = 1'b0;
                    end
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // entry valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        id_reg     <= id_next;
        handle_reg <= handle_next;
        usage_reg  <= usage_next;
    end

endmodule

// ===== rtl/core/refcounted_subject_handle_table.sv =====
// A request is registered in the capture registers and then resolved by one
// pass along the row of cells into the response register; no new request is
// taken until the current one is resolved, but a new request is taken while
// a finished response waits in its register.
// Reset: all entries free, next handle 1, live count 0; no clearing pass.
// ----------------------------------------------------------------------------
// refcounted_subject_handle_table: reference-counted subject handle table
// Create, delete, query and find over a row of entry cells.
// ----------------------------------------------------------------------------
module refcounted_subject_handle_table
    import rsht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rsht_req_if.sink   req,
    rsht_rsp_if.source rsp
);

    // request capture
    logic                busy_reg;
    logic                busy_next;
    logic [OP_W-1:0]     op_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [ID_W-1:0]     id_reg;
    logic [HRAW_W-1:0]   hraw_reg;

    // table-wide state
    logic [HANDLE_BITS-1:0] next_handle_reg;
    logic [HANDLE_BITS-1:0] next_handle_next;
    logic [LIVE_W-1:0]      live_count_reg;
    logic [LIVE_W-1:0]      live_count_next;

    // response register
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [RH_W-1:0]     rh_reg;
    logic [RH_W-1:0]     rh_next;
    logic [TYPE_W-1:0]   rt_reg;
    logic [TYPE_W-1:0]   rt_next;
    logic [ID_W-1:0]     rid_reg;
    logic [ID_W-1:0]     rid_next;
    logic [USAGE_W-1:0]  ru_reg;
    logic [USAGE_W-1:0]  ru_next;

    logic        accept;
    logic        exec;
    logic        user0;
    logic        hneg;
    logic        hminus1;
    rsht_cmd_t   cmd;
    rsht_chain_t chain [TABLE_ENTRIES+1];
    rsht_chain_t last;

    assign accept    = req.valid && req.ready;
    assign exec      = busy_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !busy_reg;

    assign user0   = (type_reg == '0) && (id_reg == '0);
    assign hneg    = hraw_reg[HRAW_W-1];
    assign hminus1 = (hraw_reg == {HRAW_W{1'b1}});

    // row of entry cells
    assign chain[0] = '0;
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            rsht_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .chain_in  (chain[gi]),
                .chain_out (chain[gi+1])
            );
        end
    endgenerate
    assign last = chain[TABLE_ENTRIES];

    // command and response decision
    always_comb
    begin
        cmd.subject_type = type_reg;
        cmd.subject_id   = id_reg;
        cmd.new_handle   = user0 ? '0 : next_handle_reg;
        cmd.action       = ACT_NONE;
        cmd.key_en       = 1'b0;
        cmd.key          = KEY_W'(hraw_reg[RH_W-1:0]);

        next_handle_next = next_handle_reg;
        live_count_next  = live_count_reg;
        busy_next        = busy_reg;
        rsp_valid_next   = rsp_valid_reg;
        status_next      = status_reg;
        rh_next          = rh_reg;
        rt_next          = rt_reg;
        rid_next         = rid_reg;
        ru_next          = ru_reg;

        // handle key per operation
        case (op_reg)
            OP_CREATE:
            begin
                cmd.key_en = 1'b1;
                cmd.key    = KEY_W'(cmd.new_handle);
            end
            OP_DELETE:
            begin
                cmd.key_en = !hneg;
            end
            OP_QUERY:
            begin
                cmd.key_en = !hneg || hminus1;
                if (hminus1)
                begin
                    cmd.key = '0;
                end
            end
            default:
            begin
                cmd.key_en = 1'b0;
            end
        endcase

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end

        if (exec)
        begin
            busy_next      = 1'b0;
            rsp_valid_next = 1'b1;
            status_next    = ST_OK;
            rh_next        = '0;
            rt_next        = '0;
            rid_next       = '0;
            ru_next        = '0;
            case (op_reg)
                OP_CREATE:
                begin
                    if (last.id_hit)
                    begin
                        cmd.action = ACT_INC;
                        rh_next    = RH_W'(KEY_W'(last.id_handle));
                        ru_next    = (last.id_usage == USAGE_MAX) ? USAGE_MAX
                                     : last.id_usage + USAGE_W'(1);
                    end
                    else if (!last.free_hit)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        if (!user0)
                        begin
                            next_handle_next = next_handle_reg + HANDLE_BITS'(1);
                        end
                        if (last.hnd_hit)
                        begin
                            status_next = ST_INTEGRITY;
                        end
                        else
                        begin
                            cmd.action      = ACT_ALLOC;
                            live_count_next = live_count_reg + LIVE_W'(1);
                            rh_next         = RH_W'(KEY_W'(cmd.new_handle));
                            ru_next         = USAGE_W'(1);
                        end
                    end
                end
                OP_DELETE:
                begin
                    if (!last.hnd_hit)
                    begin
                        status_next = ST_BAD_HANDLE;
                    end
                    else if (last.h_usage == '0)
                    begin
                        status_next = ST_INTEGRITY;
                    end
                    else
                    begin
                        cmd.action = ACT_DEC;
                        if ((last.h_usage == USAGE_W'(1)) && (live_count_reg != '0))
                        begin
                            live_count_next = live_count_reg - LIVE_W'(1);
                        end
                    end
                end
                OP_QUERY:
                begin
                    if (!last.hnd_hit)
                    begin
                        status_next = ST_BAD_HANDLE;
                    end
                    else
                    begin
                        rh_next  = RH_W'(KEY_W'(last.h_handle));
                        rt_next  = last.h_type;
                        rid_next = last.h_id;
                        ru_next  = last.h_usage;
                    end
                end
                default:
                begin
                    if (!last.id_hit)
                    begin
                        status_next = ST_BAD_ID;
                    end
                    else
                    begin
                        rh_next = RH_W'(KEY_W'(last.id_handle));
                    end
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            next_handle_reg <= HANDLE_BITS'(1);
            live_count_reg  <= '0;
        end
        else
        begin
            busy_reg        <= busy_next;
            rsp_valid_reg   <= rsp_valid_next;
            next_handle_reg <= next_handle_next;
            live_count_reg  <= live_count_next;
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.opcode;
            type_reg <= req.subject_type;
            id_reg   <= req.subject_id;
            hraw_reg <= req.subject_handle;
        end
        status_reg <= status_next;
        rh_reg     <= rh_next;
        rt_reg     <= rt_next;
        rid_reg    <= rid_next;
        ru_reg     <= ru_next;
    end

    // response outputs
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.result_handle = rh_reg;
    assign rsp.result_type   = rt_reg;
    assign rsp.result_id     = rid_reg;
    assign rsp.usage_count   = ru_reg;

endmodule

// ===== rtl/core/rsht_checker.sv =====
// ----------------------------------------------------------------------------
// rsht_checker: port-level checks of the subject handle table
// Watches the request and response channels over time; bound to the top.
// ----------------------------------------------------------------------------
module rsht_checker
    import rsht_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [RH_W-1:0]     result_handle,
    input logic [TYPE_W-1:0]   result_type,
    input logic [ID_W-1:0]     result_id,
    input logic [USAGE_W-1:0]  usage_count
);

    // a waiting response stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // only one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // failed transactions carry zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (result_handle == '0) && (result_type == '0)
            && (result_id == '0) && (usage_count == '0))
        else $error("nonzero fields on failed response");

    // status is a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_FULL))
        else $error("undefined status code");

    // a fresh response must be caused by a taken request
    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without request");

endmodule

bind refcounted_subject_handle_table rsht_checker u_rsht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .result_handle (rsp.result_handle),
    .result_type   (rsp.result_type),
    .result_id     (rsp.result_id),
    .usage_count   (rsp.usage_count)
);
